[sv/dme_pkg.sv]
// dme_pkg: shared constants, register indexes and sequencer state type
// for the digit modular exponentiation block.
// No dependencies.
`timescale 1ns / 1ps

package dme_pkg;

    // modulus arithmetic width (4 to 32)
    localparam int MOD_WIDTH = 16;
    localparam int MOD_CNT_W = $clog2(MOD_WIDTH);

    // fixed field widths
    localparam int CHAR_W     = 8;
    localparam int RES_W      = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int EXP_W      = 16;
    localparam int BASE_W     = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = CFG_IDX_W'(1);

    // reset values
    localparam logic [MOD_WIDTH-1:0] MODULUS_RST  = MOD_WIDTH'(2);
    localparam logic [EXP_W-1:0]     EXPONENT_RST = EXP_W'(1);

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'd48;
    localparam logic [CHAR_W-1:0] ASCII_NINE = 8'd57;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE_GO,
        ST_BASE_WAIT,
        ST_STEP,
        ST_MUL_WAIT,
        ST_SQ_GO,
        ST_SQ_WAIT,
        ST_DONE
    } dme_state_t;

endpackage

[sv/dme_mulmod.sv]
// dme_mulmod: bit-serial interleaved modular multiplier, one bit of the
// multiplier per cycle, MSB first. Needs a < m and m >= 1.
// Depends on dme_pkg.
`timescale 1ns / 1ps

module dme_mulmod (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [dme_pkg::MOD_WIDTH-1:0] op_a,
    input  logic [dme_pkg::MOD_WIDTH-1:0] op_b,
    input  logic [dme_pkg::MOD_WIDTH-1:0] op_m,
    output logic                          done,
    output logic [dme_pkg::MOD_WIDTH-1:0] result
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [dme_pkg::MOD_CNT_W-1:0] cnt_reg, cnt_next;
    logic [dme_pkg::MOD_WIDTH-1:0] a_reg, a_next;
    logic [dme_pkg::MOD_WIDTH-1:0] b_reg, b_next;
    logic [dme_pkg::MOD_WIDTH-1:0] m_reg, m_next;
    logic [dme_pkg::MOD_WIDTH-1:0] r_reg, r_next;

    logic [dme_pkg::MOD_WIDTH:0] dbl;
    logic [dme_pkg::MOD_WIDTH:0] dbl_red;
    logic [dme_pkg::MOD_WIDTH:0] sum;
    logic [dme_pkg::MOD_WIDTH:0] sum_red;
    logic [dme_pkg::MOD_WIDTH:0] m_ext;

    // one step: r = (2r mod m + bit * a) mod m, each part below 2m
    always_comb begin
        m_ext   = {1'b0, m_reg};
        dbl     = {r_reg, 1'b0};
        dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
        sum     = dbl_red + (b_reg[dme_pkg::MOD_WIDTH-1] ? {1'b0, a_reg} : '0);
        sum_red = (sum >= m_ext) ? sum - m_ext : sum;
    end

    // load operands on start, then advance one multiplier bit a cycle
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        r_next    = r_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = dme_pkg::MOD_CNT_W'(dme_pkg::MOD_WIDTH - 1);
            a_next    = op_a;
            b_next    = op_b;
            m_next    = op_m;
            r_next    = '0;
        end else if (busy_reg) begin
            r_next   = sum_red[dme_pkg::MOD_WIDTH-1:0];
            b_next   = {b_reg[dme_pkg::MOD_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        m_reg   <= m_next;
        r_reg   <= r_next;
    end

    assign done   = done_reg;
    assign result = r_reg;

endmodule

[sv/dme_cfg_regs.sv]
// dme_cfg_regs: modulus and exponent configuration registers behind a
// valid/ready write channel. Writes to unknown indexes are dropped.
// Depends on dme_pkg.
`timescale 1ns / 1ps

module dme_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dme_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dme_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic [dme_pkg::MOD_WIDTH-1:0]  modulus,
    output logic [dme_pkg::EXP_W-1:0]      exponent
);

    logic [dme_pkg::MOD_WIDTH-1:0] modulus_reg, modulus_next;
    logic [dme_pkg::EXP_W-1:0]     exponent_reg, exponent_next;

    // decode the write index
    always_comb begin
        modulus_next  = modulus_reg;
        exponent_next = exponent_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                dme_pkg::REG_MODULUS:  modulus_next  = dme_pkg::MOD_WIDTH'(cfg_data);
                dme_pkg::REG_EXPONENT: exponent_next = dme_pkg::EXP_W'(cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg  <= dme_pkg::MODULUS_RST;
            exponent_reg <= dme_pkg::EXPONENT_RST;
        end else begin
            modulus_reg  <= modulus_next;
            exponent_reg <= exponent_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign modulus   = modulus_reg;
    assign exponent  = exponent_reg;

endmodule

[sv/digit_modular_exponentiation.sv]
// digit_modular_exponentiation: top level; square-and-multiply sequencer
// around one shared bit-serial modular multiplier, plus result register.
// Depends on dme_pkg, dme_mulmod, dme_cfg_regs.
//
//  channel   ports                                   direction
//  input     s_valid s_ready s_char_in               in
//  result    m_valid m_ready m_residue m_cipher_byte  out
//            m_bad_char
//  config    cfg_valid cfg_ready cfg_index cfg_data  in
//
// A digit is first reduced mod m in the shared multiplier (base reduction);
// then, per exponent bit from the LSB, a multiply when the bit is set and a
// square, until the exponent is zero. A non-digit or a zero modulus skips
// the multiplier and goes straight to the result register.
// Input is taken only while the sequencer is idle; a finished result waits
// in the output register, and the next character may be taken meanwhile.
// Reset (aresetn, synchronous) restores modulus 2 and exponent 1.
`timescale 1ns / 1ps

module digit_modular_exponentiation (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [dme_pkg::CHAR_W-1:0]     s_char_in,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [dme_pkg::RES_W-1:0]      m_residue,
    output logic [dme_pkg::CHAR_W-1:0]     m_cipher_byte,
    output logic                           m_bad_char,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dme_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dme_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic [dme_pkg::MOD_WIDTH-1:0] modulus;
    logic [dme_pkg::EXP_W-1:0]     exponent;

    dme_pkg::dme_state_t state_reg, state_next;

    logic [dme_pkg::BASE_W-1:0]    base_reg, base_next;
    logic [dme_pkg::MOD_WIDTH-1:0] acc_reg, acc_next;
    logic [dme_pkg::MOD_WIDTH-1:0] sq_reg, sq_next;
    logic [dme_pkg::EXP_W-1:0]     exp_reg, exp_next;
    logic                          bad_reg, bad_next;

    logic                          out_valid_reg, out_valid_next;
    logic [dme_pkg::RES_W-1:0]     out_res_reg, out_res_next;
    logic [dme_pkg::CHAR_W-1:0]    out_cb_reg, out_cb_next;
    logic                          out_bad_reg, out_bad_next;

    logic                          mul_start;
    logic [dme_pkg::MOD_WIDTH-1:0] mul_a;
    logic [dme_pkg::MOD_WIDTH-1:0] mul_b;
    logic                          mul_done;
    logic [dme_pkg::MOD_WIDTH-1:0] mul_res;

    logic                          is_digit;
    logic [dme_pkg::CHAR_W-1:0]    digit_val;
    logic [dme_pkg::MOD_WIDTH-1:0] one_mod;
    logic                          in_accept;

    dme_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .modulus   (modulus),
        .exponent  (exponent)
    );

    dme_mulmod u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .op_m    (modulus),
        .done    (mul_done),
        .result  (mul_res)
    );

    // classify the character and form 1 mod m
    always_comb begin
        is_digit  = (s_char_in >= dme_pkg::ASCII_ZERO) && (s_char_in <= dme_pkg::ASCII_NINE);
        digit_val = s_char_in - dme_pkg::ASCII_ZERO;
        one_mod   = (modulus == dme_pkg::MOD_WIDTH'(1)) ? '0 : dme_pkg::MOD_WIDTH'(1);
        in_accept = s_valid && s_ready;
    end

    // sequencer: base reduction, then square-and-multiply from exponent LSB
    always_comb begin
        state_next     = state_reg;
        base_next      = base_reg;
        acc_next       = acc_reg;
        sq_next        = sq_reg;
        exp_next       = exp_reg;
        bad_next       = bad_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        out_cb_next    = out_cb_reg;
        out_bad_next   = out_bad_reg;
        mul_start      = 1'b0;
        mul_a          = acc_reg;
        mul_b          = sq_reg;
        s_ready        = 1'b0;

        // drop the result once taken
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            dme_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (in_accept) begin
                    base_next = digit_val[dme_pkg::BASE_W-1:0];
                    acc_next  = one_mod;
                    exp_next  = exponent;
                    bad_next  = !is_digit;
                    if (!is_digit || modulus == '0) begin
                        acc_next   = '0;
                        state_next = dme_pkg::ST_DONE;
                    end else begin
                        state_next = dme_pkg::ST_BASE_GO;
                    end
                end
            end
            dme_pkg::ST_BASE_GO: begin
                // base mod m as (1 mod m) * base
                mul_start  = 1'b1;
                mul_a      = acc_reg;
                mul_b      = dme_pkg::MOD_WIDTH'(base_reg);
                state_next = dme_pkg::ST_BASE_WAIT;
            end
            dme_pkg::ST_BASE_WAIT: begin
                if (mul_done) begin
                    sq_next    = mul_res;
                    state_next = dme_pkg::ST_STEP;
                end
            end
            dme_pkg::ST_STEP: begin
                if (exp_reg == '0) begin
                    state_next = dme_pkg::ST_DONE;
                end else if (exp_reg[0]) begin
                    mul_start  = 1'b1;
                    mul_a      = acc_reg;
                    mul_b      = sq_reg;
                    state_next = dme_pkg::ST_MUL_WAIT;
                end else begin
                    state_next = dme_pkg::ST_SQ_GO;
                end
            end
            dme_pkg::ST_MUL_WAIT: begin
                if (mul_done) begin
                    acc_next   = mul_res;
                    state_next = dme_pkg::ST_SQ_GO;
                end
            end
            dme_pkg::ST_SQ_GO: begin
                mul_start  = 1'b1;
                mul_a      = sq_reg;
                mul_b      = sq_reg;
                state_next = dme_pkg::ST_SQ_WAIT;
            end
            dme_pkg::ST_SQ_WAIT: begin
                if (mul_done) begin
                    sq_next    = mul_res;
                    exp_next   = exp_reg >> 1;
                    state_next = dme_pkg::ST_STEP;
                end
            end
            dme_pkg::ST_DONE: begin
                // hold until the output register is free
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    out_res_next   = dme_pkg::RES_W'(acc_reg);
                    out_cb_next    = dme_pkg::CHAR_W'(acc_reg) + dme_pkg::ASCII_ZERO;
                    out_bad_next   = bad_reg;
                    state_next     = dme_pkg::ST_IDLE;
                end
            end
            default: state_next = dme_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= dme_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        base_reg    <= base_next;
        acc_reg     <= acc_next;
        sq_reg      <= sq_next;
        exp_reg     <= exp_next;
        bad_reg     <= bad_next;
        out_res_reg <= out_res_next;
        out_cb_reg  <= out_cb_next;
        out_bad_reg <= out_bad_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_residue     = out_res_reg;
    assign m_cipher_byte = out_cb_reg;
    assign m_bad_char    = out_bad_reg;

endmodule
